>>> hdl/vtis_pkg.sv
`default_nettype none
package vtis_pkg;

    localparam logic [1:0] REQ_PASS   = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_STRIP  = 2'd2;

    localparam logic [15:0] TPID_RESET = 16'h8100;

    // Byte positions within the frame header.
    localparam logic [4:0] POS_ADDR_LAST = 5'd11;
    localparam logic [4:0] POS_TPID_HI   = 5'd12;
    localparam logic [4:0] POS_TPID_LO   = 5'd13;
    localparam logic [4:0] POS_TAG_HI    = 5'd14;
    localparam logic [4:0] POS_TAG_LO    = 5'd15;
    localparam logic [4:0] POS_SAT       = 5'd16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // One item's worth of output bytes, as classified by the front end.
    typedef struct packed {
        logic [2:0]      count;
        logic [4:0][7:0] bytes;
        logic            last;
        logic            stripped;
        logic [15:0]     tag;
    } vtis_rec_t;

    typedef struct packed {
        logic       full;
        logic       empty;
    } vtis_qstat_t;

    typedef struct packed {
        logic [4:0] pos;
        logic [1:0] req;
    } vtis_fstat_t;

endpackage
`default_nettype wire

>>> hdl/vtis_in_if.sv
`default_nettype none
interface vtis_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [1:0]  req_type;
    logic [15:0] insert_tag;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    output req_type, output insert_tag, input ready);
    modport sink (input valid, input data_byte, input first_byte, input last_byte,
                  input req_type, input insert_tag, output ready);
endinterface
`default_nettype wire

>>> hdl/vtis_out_if.sv
`default_nettype none
interface vtis_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        tag_stripped;
    logic [15:0] stripped_tag;

    modport source (output valid, output out_byte, output out_last, output tag_stripped,
                    output stripped_tag, input ready);
    modport sink (input valid, input out_byte, input out_last, input tag_stripped,
                  input stripped_tag, output ready);
endinterface
`default_nettype wire

>>> hdl/vtis_front.sv
`default_nettype none
module vtis_front
    import vtis_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    vtis_in_if.sink          ingress,
    input  wire logic [15:0] tpid,
    input  wire vtis_qstat_t qstat,
    output vtis_rec_t        push_rec,
    output logic             push,
    output vtis_fstat_t      fstat
);

    logic [4:0]  pos_reg, pos_next;
    logic [1:0]  req_reg, req_next;
    logic [15:0] tag_reg, tag_next;
    logic        matched_reg, matched_next;
    logic [7:0]  held_reg [3];
    logic [7:0]  held_next [3];

    logic [4:0]  pos_cur;
    logic [1:0]  req_cur;
    logic [15:0] tag_cur;
    logic        matched_cur;
    logic        accept;
    logic [7:0]  b;
    logic        lst;
    vtis_rec_t   rec;

    assign ingress.ready = !qstat.full;
    assign accept        = ingress.valid && !qstat.full;
    assign b             = ingress.data_byte;
    assign lst           = ingress.last_byte;

    always_comb
    begin
        if (ingress.first_byte)
        begin
            pos_cur     = '0;
            req_cur     = (ingress.req_type == REQ_INSERT || ingress.req_type == REQ_STRIP)
                          ? ingress.req_type : REQ_PASS;
            tag_cur     = ingress.insert_tag;
            matched_cur = 1'b0;
        end
        else
        begin
            pos_cur     = pos_reg;
            req_cur     = req_reg;
            tag_cur     = tag_reg;
            matched_cur = matched_reg;
        end

        rec          = '0;
        rec.count    = 3'd1;
        rec.bytes[0] = b;
        rec.last     = lst;
        tag_next     = tag_cur;
        matched_next = matched_cur;
        held_next    = held_reg;

        unique case (req_cur)
            REQ_INSERT:
            begin
                if (pos_cur == POS_ADDR_LAST)
                begin
                    rec.count    = 3'd5;
                    rec.bytes[1] = tpid[15:8];
                    rec.bytes[2] = tpid[7:0];
                    rec.bytes[3] = tag_cur[15:8];
                    rec.bytes[4] = tag_cur[7:0];
                end
            end
            REQ_STRIP:
            begin
                if (pos_cur < POS_TPID_HI)
                begin
                    rec.count = 3'd1;
                end
                else if (pos_cur == POS_TPID_HI)
                begin
                    if (!lst)
                    begin
                        rec.count    = 3'd0;
                        held_next[0] = b;
                    end
                end
                else if (pos_cur == POS_TPID_LO)
                begin
                    if ({held_reg[0], b} == tpid && !lst)
                    begin
                        rec.count    = 3'd0;
                        held_next[1] = b;
                        matched_next = 1'b1;
                    end
                    else
                    begin
                        rec.count    = 3'd2;
                        rec.bytes[0] = held_reg[0];
                        rec.bytes[1] = b;
                    end
                end
                else if (!matched_cur)
                begin
                    rec.count = 3'd1;
                end
                else if (pos_cur == POS_TAG_HI)
                begin
                    if (lst)
                    begin
                        rec.count    = 3'd3;
                        rec.bytes[0] = held_reg[0];
                        rec.bytes[1] = held_reg[1];
                        rec.bytes[2] = b;
                    end
                    else
                    begin
                        rec.count    = 3'd0;
                        held_next[2] = b;
                    end
                end
                else if (pos_cur == POS_TAG_LO)
                begin
                    if (lst)
                    begin
                        rec.count    = 3'd4;
                        rec.bytes[0] = held_reg[0];
                        rec.bytes[1] = held_reg[1];
                        rec.bytes[2] = held_reg[2];
                        rec.bytes[3] = b;
                    end
                    else
                    begin
                        rec.count = 3'd0;
                        tag_next  = {held_reg[2], b};
                    end
                end
                else
                begin
                    rec.stripped = lst;
                    rec.tag      = lst ? tag_cur : 16'd0;
                end
            end
            default:
            begin
                rec.count = 3'd1;
            end
        endcase

        if (lst)
        begin
            pos_next     = '0;
            req_next     = REQ_PASS;
            matched_next = 1'b0;
        end
        else
        begin
            pos_next = (pos_cur < POS_SAT) ? 5'(pos_cur + 5'd1) : POS_SAT;
            req_next = req_cur;
        end
    end

    assign push     = accept && (rec.count != 3'd0);
    assign push_rec = rec;
    assign fstat    = '{pos: pos_reg, req: req_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            req_reg     <= REQ_PASS;
            tag_reg     <= '0;
            matched_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            req_reg     <= req_next;
            tag_reg     <= tag_next;
            matched_reg <= matched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/vtis_queue.sv
`default_nettype none
module vtis_queue
    import vtis_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire vtis_rec_t push_rec,
    input  wire logic      pop,
    output vtis_rec_t      head,
    output vtis_qstat_t    qstat
);

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_W:0]   CNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

    vtis_rec_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_pop;

    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);
    assign head        = entry_reg[rd_ptr_reg];
    assign do_pop      = pop && !qstat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !do_pop)
            begin
                count_reg <= (QPTR_W + 1)'(count_reg + 1'b1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= (QPTR_W + 1)'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule
`default_nettype wire

>>> hdl/vtis_back.sv
`default_nettype none
module vtis_back
    import vtis_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire vtis_rec_t   head,
    input  wire vtis_qstat_t qstat,
    output logic             pop,
    vtis_out_if.source       egress
);

    logic [2:0]  idx_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        stripped_reg;
    logic [15:0] tag_reg;
    logic        load;
    logic        final_byte;

    // The output register is refilled whenever it is empty or being taken.
    assign load       = !qstat.empty && (!valid_reg || egress.ready);
    assign final_byte = (idx_reg == 3'(head.count - 3'd1));
    assign pop        = load && final_byte;

    assign egress.valid        = valid_reg;
    assign egress.out_byte     = byte_reg;
    assign egress.out_last     = last_reg;
    assign egress.tag_stripped = stripped_reg;
    assign egress.stripped_tag = tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg   <= final_byte ? 3'd0 : 3'(idx_reg + 3'd1);
                valid_reg <= 1'b1;
            end
            else if (egress.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= head.bytes[idx_reg];
            last_reg     <= final_byte && head.last;
            stripped_reg <= final_byte && head.stripped;
            tag_reg      <= final_byte ? head.tag : 16'd0;
        end
    end

endmodule
`default_nettype wire

>>> hdl/vlan_tag_insert_strip.sv
// VLAN tag insert and strip on a byte-wide frame stream.
// The ingress channel carries one frame byte per request, with first and last
// markers; the request type and the tag to insert are latched on the first byte.
// The egress channel returns the rewritten frame one byte per request, with the
// removed tag reported alongside the last byte of a stripped frame.
// The TPID register is written through cfg_we and cfg_wdata; the user must write
// it only while the block is idle, which the block itself does not enforce.
// A front stage classifies each byte and turns it into zero to five output bytes,
// a two-entry queue decouples it from a back stage that sends one byte per cycle
// while egress is ready through a registered output. Throughput is one byte per
// cycle; the back stage's single output byte per cycle sets this, so the twelfth
// byte of an insert frame, which yields five bytes, can hold the ingress side.
// A strip frame whose TPID matches drops four bytes; where a strip frame releases
// two to four held bytes at once, the ingress side can stall while they drain.
// Reset clears the frame state and the queue and sets the TPID to 0x8100.
// When egress stalls, the output byte holds and the queue fills; ingress ready
// drops once the queue is full.
`default_nettype none
module vlan_tag_insert_strip
    import vtis_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    vtis_in_if.sink          ingress,
    vtis_out_if.source       egress,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    logic [15:0] tpid_reg;
    vtis_rec_t   push_rec;
    vtis_rec_t   head;
    vtis_qstat_t qstat;
    vtis_fstat_t fstat;
    logic        push;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpid_reg <= TPID_RESET;
        end
        else if (cfg_we)
        begin
            tpid_reg <= cfg_wdata;
        end
    end

    vtis_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .ingress  (ingress),
        .tpid     (tpid_reg),
        .qstat    (qstat),
        .push_rec (push_rec),
        .push     (push),
        .fstat    (fstat)
    );

    vtis_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    vtis_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .egress (egress)
    );

`ifndef SYNTH
    // A tag is only ever reported on the final byte of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        egress.valid && egress.tag_stripped |-> egress.out_last)
    else $error("tag reported away from the last byte");

    // Without a stripped tag the tag field stays clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        egress.valid && !egress.tag_stripped |-> egress.stripped_tag == 16'd0)
    else $error("stripped tag set without tag_stripped");

    // Accepting a last byte returns the front end to the start of a pass frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        ingress.valid && ingress.ready && ingress.last_byte
        |=> fstat.pos == 5'd0 && fstat.req == REQ_PASS)
    else $error("frame state not cleared after last byte");

    // The queue is never written while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
    else $error("queue overrun");
`endif

endmodule
`default_nettype wire
